// ----- src/mtp_pkg.sv -----
// mtp_pkg: shared widths, payload structs and status codes for the
// move-towards-point pipeline; depends on nothing
package mtp_pkg;

  localparam int CW          = 32;         // coordinate width
  localparam int DW          = CW + 1;     // coordinate difference / magnitude
  localparam int SW          = 2 * DW + 1; // squared distance
  localparam int PW          = DW + CW - 1; // magnitude times step
  localparam int RW          = CW + 2;     // square root of squared distance
  localparam int QW          = DW;         // offset quotient
  localparam int SQRT_STAGES = RW;
  localparam int DIV_STAGES  = QW;

  typedef enum logic [1:0] {
    ST_PART  = 2'd0,
    ST_REACH = 2'd1,
    ST_ZERO  = 2'd2,
    ST_NEG   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] src_x;
    logic signed [CW-1:0] src_y;
    logic signed [CW-1:0] dst_x;
    logic signed [CW-1:0] dst_y;
    logic signed [CW-1:0] step_length;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    status_t              status;
  } out_t;

  typedef struct packed {
    logic [CW-1:0] src_x;
    logic [CW-1:0] src_y;
    logic [CW-1:0] dst_x;
    logic [CW-1:0] dst_y;
    logic          neg_x;
    logic          neg_y;
    status_t       status;
  } side_t;

  typedef struct packed {
    side_t         side;
    logic [PW-1:0] prod_x;
    logic [PW-1:0] prod_y;
  } mid_t;

endpackage

// ----- src/mtp_front.sv -----
// mtp_front: four-stage front end, differences, magnitudes, squares and products, classification
// depends on mtp_pkg
module mtp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mtp_pkg::in_t   in_data,
  output logic           out_valid,
  output logic [mtp_pkg::SW-1:0] out_sq,
  output mtp_pkg::mid_t  out_mid
);
  import mtp_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r;
  in_t                  p1_r, p2_r, p3_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic [DW-1:0]        ax2_r, ay2_r;
  logic                 nx2_r, ny2_r, nx3_r, ny3_r;
  logic [2*DW-1:0]      sqx3_r, sqy3_r;
  logic [2*CW-3:0]      ssq3_r;
  logic [PW-1:0]        px3_r, py3_r;
  logic [SW-1:0]        sq4_r;
  mid_t                 mid4_r;

  logic [SW-1:0] sum_c;
  status_t       st_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign sum_c = {1'b0, sqx3_r} + {1'b0, sqy3_r};

  always_comb begin
    priority if (p3_r.step_length[CW-1]) begin
      st_c = ST_NEG;
    end else if (p3_r.step_length == '0) begin
      st_c = ST_ZERO;
    end else if (sum_c <= {{(SW-2*CW+2){1'b0}}, ssq3_r}) begin
      st_c = ST_REACH;
    end else begin
      st_c = ST_PART;
    end
  end

  always_ff @(posedge clk) begin
    // differences
    p1_r  <= in_data;
    dx1_r <= {in_data.dst_x[CW-1], in_data.dst_x} - {in_data.src_x[CW-1], in_data.src_x};
    dy1_r <= {in_data.dst_y[CW-1], in_data.dst_y} - {in_data.src_y[CW-1], in_data.src_y};
    // magnitudes
    p2_r  <= p1_r;
    nx2_r <= dx1_r[DW-1];
    ny2_r <= dy1_r[DW-1];
    ax2_r <= dx1_r[DW-1] ? $unsigned(-dx1_r) : $unsigned(dx1_r);
    ay2_r <= dy1_r[DW-1] ? $unsigned(-dy1_r) : $unsigned(dy1_r);
    // squares and products
    p3_r   <= p2_r;
    nx3_r  <= nx2_r;
    ny3_r  <= ny2_r;
    sqx3_r <= {{DW{1'b0}}, ax2_r} * {{DW{1'b0}}, ax2_r};
    sqy3_r <= {{DW{1'b0}}, ay2_r} * {{DW{1'b0}}, ay2_r};
    ssq3_r <= {{(CW-1){1'b0}}, p2_r.step_length[CW-2:0]}
            * {{(CW-1){1'b0}}, p2_r.step_length[CW-2:0]};
    px3_r  <= {{(CW-1){1'b0}}, ax2_r} * {{DW{1'b0}}, p2_r.step_length[CW-2:0]};
    py3_r  <= {{(CW-1){1'b0}}, ay2_r} * {{DW{1'b0}}, p2_r.step_length[CW-2:0]};
    // sum and classify
    sq4_r              <= sum_c;
    mid4_r.side.src_x  <= p3_r.src_x;
    mid4_r.side.src_y  <= p3_r.src_y;
    mid4_r.side.dst_x  <= p3_r.dst_x;
    mid4_r.side.dst_y  <= p3_r.dst_y;
    mid4_r.side.neg_x  <= nx3_r;
    mid4_r.side.neg_y  <= ny3_r;
    mid4_r.side.status <= st_c;
    mid4_r.prod_x      <= px3_r;
    mid4_r.prod_y      <= py3_r;
  end

  assign out_valid = v4_r;
  assign out_sq    = sq4_r;
  assign out_mid   = mid4_r;

endmodule

// ----- src/mtp_sqrt.sv -----
// mtp_sqrt: pipelined integer square root, one result bit per stage
// depends on mtp_pkg
module mtp_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [mtp_pkg::SW-1:0] in_sq,
  output logic                   out_valid,
  output logic [mtp_pkg::RW-1:0] out_root
);
  import mtp_pkg::*;

  localparam int AW = 2 * RW;  // radicand padded to an even width
  localparam int MW = RW + 3;  // partial remainder

  logic          v_r    [SQRT_STAGES+1];
  logic [AW-1:0] rad_r  [SQRT_STAGES+1];
  logic [MW-1:0] rem_r  [SQRT_STAGES+1];
  logic [RW-1:0] root_r [SQRT_STAGES+1];

  always_comb begin
    v_r[0]    = in_valid;
    rad_r[0]  = {{(AW-SW){1'b0}}, in_sq};
    rem_r[0]  = '0;
    root_r[0] = '0;
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [MW-1:0] nrem_c;
    logic [MW-1:0] trial_c;
    logic          ge_c;

    assign nrem_c  = {rem_r[k][MW-3:0], rad_r[k][AW-1:AW-2]};
    assign trial_c = {1'b0, root_r[k], 2'b01};
    assign ge_c    = nrem_c >= trial_c;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rad_r[k+1]  <= {rad_r[k][AW-3:0], 2'b00};
      rem_r[k+1]  <= ge_c ? nrem_c - trial_c : nrem_c;
      root_r[k+1] <= {root_r[k][RW-2:0], ge_c};
    end
  end

  assign out_valid = v_r[SQRT_STAGES];
  assign out_root  = root_r[SQRT_STAGES];

endmodule

// ----- src/mtp_div.sv -----
// mtp_div: pipelined restoring divider, one quotient bit per stage
// depends on mtp_pkg
module mtp_div (
  input  logic                   clk,
  input  logic [mtp_pkg::PW-1:0] in_num,
  input  logic [mtp_pkg::RW-1:0] in_den,
  output logic [mtp_pkg::QW-1:0] out_quot
);
  import mtp_pkg::*;

  localparam int MW = RW + 1;

  // quotient fits in QW bits, so the top numerator bits start below the divisor
  logic [MW-1:0] rem_r [DIV_STAGES+1];
  logic [QW-1:0] nb_r  [DIV_STAGES+1];
  logic [QW-1:0] q_r   [DIV_STAGES+1];
  logic [RW-1:0] den_r [DIV_STAGES+1];

  always_comb begin
    rem_r[0] = {{(MW-PW+QW){1'b0}}, in_num[PW-1:QW]};
    nb_r[0]  = in_num[QW-1:0];
    q_r[0]   = '0;
    den_r[0] = in_den;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [MW-1:0] r2_c;
    logic          ge_c;

    assign r2_c = {rem_r[k][MW-2:0], nb_r[k][QW-1]};
    assign ge_c = r2_c >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge_c ? r2_c - {1'b0, den_r[k]} : r2_c;
      nb_r[k+1]  <= {nb_r[k][QW-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][QW-2:0], ge_c};
      den_r[k+1] <= den_r[k];
    end
  end

  assign out_quot = q_r[DIV_STAGES];

endmodule

// ----- src/move_towards_point_2d.sv -----
// move_towards_point_2d: top level, step from a source point toward a target
// depends on mtp_pkg, mtp_front, mtp_sqrt, mtp_div
//
//   channel   ports                          handshake
//   input     start, busy, in_item           transaction when start && !busy
//   result    out_strobe, out_item           one-cycle strobe, no back pressure
//
// one transaction per clock; busy is never raised
// from accept to strobe a move passes the front end, the square root stages, the
// divider stages and the output register; the bit-per-stage square root and dividers set the depth
// synchronous active-low reset clears the valid bits only; payload is left as is
// nothing stalls: the receiver takes every result in the cycle it appears
module move_towards_point_2d (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mtp_pkg::in_t  in_item,
  output logic          out_strobe,
  output mtp_pkg::out_t out_item
);
  import mtp_pkg::*;

  logic          fr_valid;
  logic [SW-1:0] fr_sq;
  mid_t          fr_mid;
  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic [RW-1:0] den_c;
  logic [QW-1:0] qx, qy;

  // side data riding alongside the square root and the dividers
  mid_t          mid_r  [SQRT_STAGES];
  side_t         side_r [DIV_STAGES];
  logic          dv_r   [DIV_STAGES];

  logic          strobe_r;
  out_t          item_r;
  logic [DW:0]   offx_c, offy_c;
  side_t         fin_c;

  assign busy = 1'b0;

  mtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_item),
    .out_valid (fr_valid),
    .out_sq    (fr_sq),
    .out_mid   (fr_mid)
  );

  mtp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_sq     (fr_sq),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  // shift line matching the square root latency
  always_ff @(posedge clk) begin
    mid_r[0] <= fr_mid;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      mid_r[i] <= mid_r[i-1];
    end
  end

  // partway moves always have a root of at least one; guard anyway
  assign den_c = (sq_root == '0) ? {{(RW-1){1'b0}}, 1'b1} : sq_root;

  mtp_div u_div_x (
    .clk      (clk),
    .in_num   (mid_r[SQRT_STAGES-1].prod_x),
    .in_den   (den_c),
    .out_quot (qx)
  );

  mtp_div u_div_y (
    .clk      (clk),
    .in_num   (mid_r[SQRT_STAGES-1].prod_y),
    .in_den   (den_c),
    .out_quot (qy)
  );

  // shift line matching the divider latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else begin
      dv_r[0] <= sq_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= mid_r[SQRT_STAGES-1].side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign fin_c = side_r[DIV_STAGES-1];

  // apply the sign of the coordinate difference to each offset
  assign offx_c = fin_c.neg_x ? -{1'b0, qx} : {1'b0, qx};
  assign offy_c = fin_c.neg_y ? -{1'b0, qy} : {1'b0, qy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    item_r.status <= fin_c.status;
    unique case (fin_c.status)
      ST_NEG: begin
        item_r.out_x <= '0;
        item_r.out_y <= '0;
      end
      ST_ZERO: begin
        item_r.out_x <= fin_c.src_x;
        item_r.out_y <= fin_c.src_y;
      end
      ST_REACH: begin
        item_r.out_x <= fin_c.dst_x;
        item_r.out_y <= fin_c.dst_y;
      end
      ST_PART: begin
        item_r.out_x <= fin_c.src_x + offx_c[CW-1:0];
        item_r.out_y <= fin_c.src_y + offy_c[CW-1:0];
      end
      default: begin
        item_r.out_x <= '0;
        item_r.out_y <= '0;
      end
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ----- tb/testbench.sv -----
// testbench for move_towards_point_2d: directed table then random transactions,
// each result checked against a behavioral stepping predictor; depends on mtp_pkg and move_towards_point_2d
`timescale 1ns / 1ps

module testbench;
  import mtp_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_strobe;
  out_t out_item;

  move_towards_point_2d dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // pipeline depth of the design; a margin is added where it is used
  localparam int LATENCY   = 72;
  localparam int CYCLE_CAP = 200000;
  localparam int N_RANDOM  = 700;

  out_t   pending_moves[$];
  int     n_errors;
  int     n_checked;
  int     n_sent;
  int     n_status[4];
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // integer square root, floor, of a value below 2^67
  function automatic logic [RW-1:0] isqrt(logic [SW-1:0] s);
    logic [RW-1:0] r;
    logic [RW-1:0] t;
    r = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      t = r | (RW'(1) << b);
      if ({{(SW - RW){1'b0}}, t} * {{(SW - RW){1'b0}}, t} <= s) r = t;
    end
    return r;
  endfunction

  // expected point and status for one transaction
  function automatic out_t predict_move(in_t it);
    out_t               o;
    logic signed [DW:0] dx;
    logic signed [DW:0] dy;
    logic [DW-1:0]      ax;
    logic [DW-1:0]      ay;
    logic [SW-1:0]      dist_sq;
    logic [SW-1:0]      step_sq;
    logic [RW-1:0]      dist_rt;
    logic [95:0]        mx;
    logic [95:0]        my;
    logic [CW-1:0]      step;
    o = '0;
    if (it.step_length < 0) begin
      o.status = ST_NEG;
      return o;
    end
    if (it.step_length == 0) begin
      o.out_x  = it.src_x;
      o.out_y  = it.src_y;
      o.status = ST_ZERO;
      return o;
    end
    step    = it.step_length;
    dx      = (DW + 1)'(it.dst_x) - (DW + 1)'(it.src_x);
    dy      = (DW + 1)'(it.dst_y) - (DW + 1)'(it.src_y);
    ax      = dx < 0 ? DW'(-dx) : DW'(dx);
    ay      = dy < 0 ? DW'(-dy) : DW'(dy);
    dist_sq = SW'(ax) * SW'(ax) + SW'(ay) * SW'(ay);
    step_sq = SW'(step) * SW'(step);
    if (dist_sq <= step_sq) begin
      o.out_x  = it.dst_x;
      o.out_y  = it.dst_y;
      o.status = ST_REACH;
      return o;
    end
    dist_rt = isqrt(dist_sq);
    if (dist_rt == 0) dist_rt = 1;
    mx = (96'(ax) * 96'(step)) / 96'(dist_rt);
    my = (96'(ay) * 96'(step)) / 96'(dist_rt);
    o.out_x  = dx < 0 ? it.src_x - CW'(mx) : it.src_x + CW'(mx);
    o.out_y  = dy < 0 ? it.src_y - CW'(my) : it.src_y + CW'(my);
    o.status = ST_PART;
    return o;
  endfunction

  // one transaction: hold start until accepted, expectation queued at accept
  task automatic send_move(in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_moves.push_back(predict_move(it));
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random point: full range, clusters of several sizes around near, or extremes
  function automatic logic [CW-1:0] rand_coord(logic [CW-1:0] near);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return near + CW'($urandom_range(0, 2000)) - CW'(1000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return near + ($urandom & 32'h00ff_ffff) - 32'h0080_0000;
      default: return near + ($urandom & 32'h0fff_ffff) - 32'h0800_0000;
    endcase
  endfunction

  // result monitor: strobe sampled at the edge that ends its cycle
  always @(posedge clk) begin
    out_t exp_move;
    if (rst_n && out_strobe) begin
      if (pending_moves.size() == 0) begin
        $error("unexpected result x=%h y=%h status=%0d",
               out_item.out_x, out_item.out_y, out_item.status);
        n_errors++;
      end else begin
        exp_move = pending_moves.pop_front();
        if (out_item.out_x !== exp_move.out_x) begin
          $error("out_x expected %h actual %h", exp_move.out_x, out_item.out_x);
          n_errors++;
        end
        if (out_item.out_y !== exp_move.out_y) begin
          $error("out_y expected %h actual %h", exp_move.out_y, out_item.out_y);
          n_errors++;
        end
        if (out_item.status !== exp_move.status) begin
          $error("status expected %0d actual %0d", exp_move.status, out_item.status);
          n_errors++;
        end
        n_status[exp_move.status]++;
        n_checked++;
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed table: src_x, src_y, dst_x, dst_y, step, and typed expectation where obvious
  typedef struct {
    in_t  it;
    bit   has_exp;
    out_t exp_move;
  } move_row_t;

  move_row_t move_table[$];

  task automatic add_row(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] tx,
                         logic [CW-1:0] ty, logic [CW-1:0] st, bit has_exp,
                         logic [CW-1:0] ex, logic [CW-1:0] ey, status_t es);
    move_row_t r;
    r.it       = '{sx, sy, tx, ty, st};
    r.has_exp  = has_exp;
    r.exp_move = '{ex, ey, es};
    move_table.push_back(r);
  endtask

  initial begin
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    in_t           it;
    n_errors    = 0;
    n_checked   = 0;
    n_sent      = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;

    // negative steps: error with zero point
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0, 32'hffff_ffff,
            1, 0, 0, ST_NEG);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 1, 0, 0, ST_NEG);
    // zero step keeps the source
    add_row(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 32'h0,
            1, 32'h1234_5678, 32'h8765_4321, ST_ZERO);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
            1, 32'h8000_0000, 32'h7fff_ffff, ST_ZERO);
    // equal points reach the target
    add_row(32'h0003_0000, 32'h0004_0000, 32'h0003_0000, 32'h0004_0000, 32'h1,
            1, 32'h0003_0000, 32'h0004_0000, ST_REACH);
    // 3-4-5 triangle, step exactly the distance
    add_row(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
            1, 32'h0003_0000, 32'h0004_0000, ST_REACH);
    // largest step reaches a far diagonal target
    add_row(32'h0, 32'h0, 32'h4000_0000, 32'h4000_0000, 32'h7fff_ffff,
            1, 32'h4000_0000, 32'h4000_0000, ST_REACH);
    // partway cases, predictor checked
    add_row(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0004_ffff, 0, 0, 0, ST_PART);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1,
            0, 0, 0, ST_PART);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            0, 0, 0, ST_PART);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000,
            0, 0, 0, ST_PART);
    add_row(32'h0, 32'h0, 32'h0, 32'h0000_0002, 32'h1, 0, 0, 0, ST_PART);
    add_row(32'h0, 32'h0, 32'hffff_fffe, 32'h0, 32'h1, 0, 0, 0, ST_PART);
    add_row(32'h0001_0000, 32'hffff_0000, 32'hfff0_0000, 32'h0010_0000, 32'h0003_8000,
            0, 0, 0, ST_PART);
    add_row(32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h7fff_fffe, 0, 0, 0, ST_PART);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (move_table[i]) begin
      if (move_table[i].has_exp &&
          predict_move(move_table[i].it) !== move_table[i].exp_move) begin
        $error("directed row %0d: table and predictor disagree", i);
        n_errors++;
      end
      send_move(move_table[i].it);
      if (i % 3 == 2) idle_gap();
    end

    // random part: mostly nonnegative steps over a wide range of magnitudes
    for (int k = 0; k < N_RANDOM; k++) begin
      sx = $urandom;
      sy = $urandom;
      if ($urandom_range(0, 3) == 0) sx = rand_coord(32'h0);
      it.src_x = sx;
      it.src_y = sy;
      it.dst_x = rand_coord(sx);
      it.dst_y = rand_coord(sy);
      case ($urandom_range(0, 9))
        0:       it.step_length = $urandom | 32'h8000_0000;
        1:       it.step_length = 0;
        2:       it.step_length = $urandom & 32'h7fff_ffff;
        3:       it.step_length = $urandom_range(1, 4);
        default: it.step_length = $urandom & (32'h7fff_ffff >> $urandom_range(0, 30));
      endcase
      send_move(it);
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
    start <= 1'b0;

    while (pending_moves.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("sent %0d moves, checked %0d results", n_sent, n_checked);
    $display("partway %0d, reached %0d, zero step %0d, negative step %0d",
             n_status[ST_PART], n_status[ST_REACH], n_status[ST_ZERO], n_status[ST_NEG]);
    if (n_errors == 0 && pending_moves.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
